[rtl/s3f_pkg.sv]
// ----------------------------------------------------------------------------
// s3f_pkg: shared types and constants of the 3x3 stencil filter
// Filter mode codes, register indexes, reset values, divide-by-9 constants.
// ----------------------------------------------------------------------------
package s3f_pkg;

  // Fixed field widths of the ports
  localparam int PIX_FIELD_W   = 16;
  localparam int WIDTH_FIELD_W = 11;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 16;

  // Filter modes; the unused code falls back to box blur
  typedef enum logic [1:0] {
    MODE_BOX     = 2'd0,
    MODE_LAPLACE = 2'd1,
    MODE_SHARPEN = 2'd2
  } filter_mode_t;

  // Register indexes on the config port
  localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_MODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_VALUE    = 2'd3;

  // Register reset values
  localparam logic [WIDTH_FIELD_W-1:0] FRAME_WIDTH_RESET  = 11'd1024;
  localparam logic [PIX_FIELD_W-1:0]   FRAME_HEIGHT_RESET = 16'd768;
  localparam logic [PIX_FIELD_W-1:0]   MAX_VALUE_RESET    = 16'd255;

  // sum / 9 == (sum * DIV9_MULT) >> DIV9_SHIFT, exact for sums below 2^20
  localparam int               DIV9_WIDTH = 20;
  localparam int               DIV9_SHIFT = 23;
  localparam logic [DIV9_WIDTH-1:0] DIV9_MULT = 20'd932068;

  // Signed width used for the clamp compare
  localparam int CLAMP_WIDTH = 21;

  // Per-beat control flags carried down the pipeline
  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } item_flags_t;

endpackage

[rtl/s3f_line_store.sv]
// ----------------------------------------------------------------------------
// s3f_line_store: dual row buffer
// One entry per column holding {upper row, middle row}; registered read.
// ----------------------------------------------------------------------------
module s3f_line_store #(
  parameter int DEPTH = 1024,
  parameter int DW    = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/s3f_column_cell.sv]
// ----------------------------------------------------------------------------
// s3f_column_cell: one column of the 3x3 window
// Holds top/middle/bottom pixels; loads its neighbor's column on shift.
// ----------------------------------------------------------------------------
module s3f_column_cell #(
  parameter int PB = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  logic [2:0][PB-1:0]  col_in,
  output logic [2:0][PB-1:0]  col_out
);

  logic [2:0][PB-1:0] col;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

  assign col_out = col;

endmodule

[rtl/stencil_3x3_image_filter.sv]
// ----------------------------------------------------------------------------
// stencil_3x3_image_filter: streaming 3x3 grayscale filter
// Pixels enter in raster order and filtered pixels leave in the same order,
// one row plus one pixel behind; flush beats (kind = 1) push out the tail of
// the frame. filter_mode picks box blur (sum/9), a 4/-1 Laplacian or a 5/-1
// sharpen, the last two clamped to 0..max_value; border pixels pass through.
// Throughput is one beat per clock in both directions while out_ready does
// not hold the pipeline back: the line store does one read and one write per
// cycle and every stage after it is registered. The window is a row of three
// column cells that shift once per input beat. frame_width is clamped to
// 3..MAX_WIDTH, frame_height below 3 acts as 3; program the registers only
// while the block is idle.
// ----------------------------------------------------------------------------
module stencil_3x3_image_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // config port
  input  logic                                cfg_write,
  input  logic [s3f_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [s3f_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                kind,
  input  logic [s3f_pkg::PIX_FIELD_W-1:0]     pixel_value,
  // output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [s3f_pkg::PIX_FIELD_W-1:0]     out_pixel,
  output logic                                frame_last
);

  localparam int PB  = PIXEL_BITS;
  localparam int AW  = $clog2(MAX_WIDTH);          // line store address
  localparam int CW  = $clog2(MAX_WIDTH + 1);      // column counters
  localparam int WCW = (CW > s3f_pkg::WIDTH_FIELD_W) ? CW : s3f_pkg::WIDTH_FIELD_W;
  localparam int SW  = PB + 4;                     // nine-pixel sum
  localparam int LW  = PB + 4;                     // signed Laplacian
  localparam int PW  = 2 * s3f_pkg::DIV9_WIDTH;    // divide product

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [1:0]                              filter_mode;
  logic [s3f_pkg::WIDTH_FIELD_W-1:0]       frame_width;
  logic [s3f_pkg::PIX_FIELD_W-1:0]         frame_height;
  logic [s3f_pkg::PIX_FIELD_W-1:0]         max_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= s3f_pkg::MODE_BOX;
      frame_width  <= s3f_pkg::FRAME_WIDTH_RESET;
      frame_height <= s3f_pkg::FRAME_HEIGHT_RESET;
      max_value    <= s3f_pkg::MAX_VALUE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        s3f_pkg::CFG_FILTER_MODE:  filter_mode  <= cfg_data[1:0];
        s3f_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[s3f_pkg::WIDTH_FIELD_W-1:0];
        s3f_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        s3f_pkg::CFG_MAX_VALUE:    max_value    <= cfg_data;
        default:                   filter_mode  <= filter_mode;
      endcase
    end
  end

  // Effective frame size
  logic [WCW-1:0] fw_ext;
  logic [CW-1:0]  w_eff;
  logic [15:0]    h_eff;

  assign fw_ext = WCW'(frame_width);

  always_comb begin
    if (fw_ext < WCW'(3)) begin
      w_eff = CW'(3);
    end else if (fw_ext > WCW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext[CW-1:0];
    end
  end

  assign h_eff = (frame_height < 16'd3) ? 16'd3 : frame_height;

  // --------------------------------------------------------------------------
  // Ready chain: a stage takes a beat when it is empty or its beat moves on
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic accept;

  assign rdy5     = !out_valid || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign accept   = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Position counters, updated at accept. Emit/interior/last are settled
  // here so the beat right after a frame end already sees zeroed counters.
  // --------------------------------------------------------------------------
  logic [CW-1:0] in_column, in_column_next;
  logic [15:0]   in_row, in_row_next;
  logic [CW-1:0] out_column, out_column_next;
  logic [15:0]   out_row, out_row_next;

  logic                 past_end;
  logic [PB-1:0]        px_in;
  s3f_pkg::item_flags_t flags_in;
  logic [CW:0]          in_col_inc, out_col_inc;

  assign past_end = in_row >= h_eff;
  assign px_in    = (kind || past_end) ? '0 : pixel_value[PB-1:0];

  always_comb begin
    flags_in.emit     = (in_row > 16'd1) || (in_row == 16'd1 && in_column != '0);
    flags_in.interior = (out_row != 16'd0)
                     && ({1'b0, out_row} + 17'd2 <= {1'b0, h_eff})
                     && (out_column != '0)
                     && ({1'b0, out_column} + (CW+1)'(2) <= {1'b0, w_eff});
    flags_in.last     = ({1'b0, out_row} + 17'd1 >= {1'b0, h_eff})
                     && ({1'b0, out_column} + (CW+1)'(1) >= {1'b0, w_eff});
  end

  always_comb begin
    in_col_inc      = {1'b0, in_column} + (CW+1)'(1);
    out_col_inc     = {1'b0, out_column} + (CW+1)'(1);
    in_column_next  = in_col_inc[CW-1:0];
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (in_col_inc >= {1'b0, w_eff}) begin
      in_column_next = '0;
      in_row_next    = in_row + 16'd1;
    end
    if (flags_in.emit) begin
      if (flags_in.last) begin
        // frame done: next beat starts a new frame
        in_column_next  = '0;
        in_row_next     = '0;
        out_column_next = '0;
        out_row_next    = '0;
      end else if (out_col_inc >= {1'b0, w_eff}) begin
        out_column_next = '0;
        out_row_next    = out_row + 16'd1;
      end else begin
        out_column_next = out_col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (accept) begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: line store read data lands next to the beat
  // --------------------------------------------------------------------------
  logic [PB-1:0]        px1;
  logic [AW-1:0]        col1;
  s3f_pkg::item_flags_t f1;
  logic [2*PB-1:0]      ls_rd_data;
  logic [PB-1:0]        up1, mid1;
  logic                 shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      px1  <= px_in;
      col1 <= in_column[AW-1:0];
      f1   <= flags_in;
    end
  end

  assign up1   = ls_rd_data[2*PB-1:PB];
  assign mid1  = ls_rd_data[PB-1:0];
  assign shift = v1 && rdy2;

  // Write back {middle -> upper, new pixel -> middle} as the beat moves on
  s3f_line_store #(
    .DEPTH (MAX_WIDTH),
    .DW    (2 * PB),
    .AW    (AW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (rdy1),
    .rd_addr (in_column[AW-1:0]),
    .rd_data (ls_rd_data),
    .wr_en   (shift),
    .wr_addr (col1),
    .wr_data ({mid1, px1})
  );

  // --------------------------------------------------------------------------
  // Window: three column cells, index 2 is the newest column.
  // Within a column, [0] upper row, [1] middle row, [2] new row.
  // --------------------------------------------------------------------------
  logic [2:0][PB-1:0] new_col;
  logic [2:0][PB-1:0] win0, win1, win2;

  assign new_col = {px1, mid1, up1};

  s3f_column_cell #(.PB(PB)) u_cell2 (
    .clk (clk), .rst (rst), .shift (shift), .col_in (new_col), .col_out (win2)
  );
  s3f_column_cell #(.PB(PB)) u_cell1 (
    .clk (clk), .rst (rst), .shift (shift), .col_in (win2), .col_out (win1)
  );
  s3f_column_cell #(.PB(PB)) u_cell0 (
    .clk (clk), .rst (rst), .shift (shift), .col_in (win1), .col_out (win0)
  );

  // --------------------------------------------------------------------------
  // Stage 2: window holds the beat's neighborhood; only emitting beats stay
  // --------------------------------------------------------------------------
  s3f_pkg::item_flags_t f2;
  logic [SW-1:0]        sum2;
  logic [LW-1:0]        kc2, edges2;
  logic signed [LW-1:0] lap2;
  logic                 box2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1 && f1.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      f2 <= f1;
    end
  end

  always_comb begin
    sum2 = SW'(win0[0]) + SW'(win0[1]) + SW'(win0[2])
         + SW'(win1[0]) + SW'(win1[1]) + SW'(win1[2])
         + SW'(win2[0]) + SW'(win2[1]) + SW'(win2[2]);
    edges2 = LW'(win1[0]) + LW'(win1[2]) + LW'(win0[1]) + LW'(win2[1]);
    kc2    = (LW'(win1[1]) << 2)
           + ((filter_mode == s3f_pkg::MODE_SHARPEN) ? LW'(win1[1]) : '0);
    lap2   = $signed(kc2 - edges2);
    box2   = !(filter_mode == s3f_pkg::MODE_LAPLACE ||
               filter_mode == s3f_pkg::MODE_SHARPEN);
  end

  // --------------------------------------------------------------------------
  // Stage 3: divide by 9 through the reciprocal, clamp the Laplacian
  // --------------------------------------------------------------------------
  s3f_pkg::item_flags_t          f3;
  logic [SW-1:0]                 sum3;
  logic signed [LW-1:0]          lap3;
  logic [PB-1:0]                 c3;
  logic                          box3;
  logic [PW-1:0]                 prod3;
  logic [15:0]                   quot3, clamp3;
  logic signed [s3f_pkg::CLAMP_WIDTH-1:0] lap_ext3, max_ext3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      f3   <= f2;
      sum3 <= sum2;
      lap3 <= lap2;
      c3   <= win1[1];
      box3 <= box2;
    end
  end

  always_comb begin
    prod3    = PW'(sum3) * PW'(s3f_pkg::DIV9_MULT);
    quot3    = prod3[s3f_pkg::DIV9_SHIFT +: 16];
    lap_ext3 = s3f_pkg::CLAMP_WIDTH'(lap3);
    max_ext3 = $signed(s3f_pkg::CLAMP_WIDTH'(max_value));
    if (lap_ext3 < 0) begin
      clamp3 = '0;
    end else if (lap_ext3 > max_ext3) begin
      clamp3 = max_value;
    end else begin
      clamp3 = lap_ext3[15:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: pick filtered or border value
  // --------------------------------------------------------------------------
  s3f_pkg::item_flags_t f4;
  logic [15:0]          quot4, clamp4, value4;
  logic [PB-1:0]        c4;
  logic                 box4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      f4     <= f3;
      quot4  <= quot3;
      clamp4 <= clamp3;
      c4     <= c3;
      box4   <= box3;
    end
  end

  always_comb begin
    if (!f4.interior) begin
      value4 = 16'(c4);
    end else if (box4) begin
      value4 = quot4;
    end else begin
      value4 = clamp4;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy5) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out_pixel  <= value4;
      frame_last <= f4.last;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (in_column < CW'(MAX_WIDTH)) && (out_column < CW'(MAX_WIDTH)))
    else $error("column counter out of range");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && flags_in.emit && flags_in.last) |=>
      (in_column == '0 && in_row == '0 && out_column == '0 && out_row == '0))
    else $error("counters not cleared after frame end beat");

  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output side is free");

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression for stencil_3x3_image_filter
// Sends raster pixel beats and flush beats under random valid/ready gaps.
// A behavioral copy of the line stores, 3x3 window and position counters
// predicts every filtered beat, and each output beat is checked in order.
// Covers all mode codes, clamp limits, geometry clamping below 3, frame
// tails and back-pressure.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 12;
  localparam int LINE_DEPTH   = 1024;      // MAX_WIDTH of the instance
  localparam int DRAIN_CYCLES = 16;        // 5-stage pipe plus margin
  localparam int CYCLE_LIMIT  = 500_000;
  localparam int RANDOM_BEATS = 400;
  localparam int MAX_REPORTS  = 30;
  localparam int HOLD_OFF     = 300;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;
  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused code, decodes as box blur
  localparam logic [s3f_pkg::PIX_FIELD_W-1:0] PIX_ONES = {s3f_pkg::PIX_FIELD_W{1'b1}};

  typedef enum int {PAT_RANDOM, PAT_EXTREME, PAT_CHECKER} pixel_pattern_t;

  typedef struct packed {
    logic [s3f_pkg::PIX_FIELD_W-1:0] pixel;
    logic                            last;
  } filtered_t;

  // DUT ports; the inputs are known from time zero
  logic                            clk         = 1'b0;
  logic                            rst         = 1'b1;
  logic                            cfg_write   = 1'b0;
  logic [s3f_pkg::CFG_INDEX_W-1:0] cfg_index   = s3f_pkg::CFG_FILTER_MODE;
  logic [s3f_pkg::CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                            in_valid    = 1'b0;
  logic                            in_ready;
  logic                            kind        = KIND_PIXEL;
  logic [s3f_pkg::PIX_FIELD_W-1:0] pixel_value = '0;
  logic                            out_valid;
  logic                            out_ready   = 1'b0;
  logic [s3f_pkg::PIX_FIELD_W-1:0] out_pixel;
  logic                            frame_last;

  stencil_3x3_image_filter #(
    .MAX_WIDTH (LINE_DEPTH),
    .PIXEL_BITS(s3f_pkg::PIX_FIELD_W)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .pixel_value(pixel_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pixel  (out_pixel),
    .frame_last (frame_last)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Run bookkeeping and handshake knobs
  // --------------------------------------------------------------------------
  int unsigned cycles;
  int unsigned errors;
  int unsigned beats_accepted;
  int unsigned results_seen;
  int unsigned frames_sent;
  bit          in_gaps_on  = 1'b1;
  bit          out_gaps_on = 1'b1;
  int          hold_cycles = 0;   // one-shot long stall request for the sink

  filtered_t pending_pixels [$];  // predicted output beats, oldest first
  filtered_t want;

  // --------------------------------------------------------------------------
  // Predictor state: register mirror, line stores, window, positions
  // --------------------------------------------------------------------------
  logic [1:0]                      mode_reg;
  logic [10:0]                     width_reg;
  logic [15:0]                     height_reg;
  logic [15:0]                     maxval_reg;
  logic [s3f_pkg::PIX_FIELD_W-1:0] upper_line  [LINE_DEPTH];
  logic [s3f_pkg::PIX_FIELD_W-1:0] middle_line [LINE_DEPTH];
  int                              win [3][3];  // [row][column]; column 2 is the newest
  int unsigned                     col_in, row_in, col_out, row_out;

  function automatic void reset_predictor();
    int r, s;
    mode_reg   = s3f_pkg::MODE_BOX;
    width_reg  = s3f_pkg::FRAME_WIDTH_RESET;
    height_reg = s3f_pkg::FRAME_HEIGHT_RESET;
    maxval_reg = s3f_pkg::MAX_VALUE_RESET;
    // store contents never reach a result before written; zero is arbitrary
    for (r = 0; r < LINE_DEPTH; r++) begin
      upper_line[r]  = '0;
      middle_line[r] = '0;
    end
    for (r = 0; r < 3; r++)
      for (s = 0; s < 3; s++)
        win[r][s] = 0;
    col_in  = 0;
    row_in  = 0;
    col_out = 0;
    row_out = 0;
  endfunction

  // width register clamps to 3..LINE_DEPTH, height below 3 acts as 3
  function automatic int active_width();
    if (width_reg < 3) return 3;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return int'(width_reg);
  endfunction

  function automatic int active_height();
    if (height_reg < 3) return 3;
    return int'(height_reg);
  endfunction

  function automatic int clamp_to_max(int v);
    if (v < 0) return 0;
    if (v > int'(maxval_reg)) return int'(maxval_reg);
    return v;
  endfunction

  // Filtered centre of the current window. Any mode code other than the
  // Laplacian and sharpen codes falls back to the box blur.
  function automatic int window_value();
    int edges, total, r, s;
    edges = win[0][1] + win[2][1] + win[1][0] + win[1][2];
    if (mode_reg == s3f_pkg::MODE_LAPLACE) return clamp_to_max(4 * win[1][1] - edges);
    if (mode_reg == s3f_pkg::MODE_SHARPEN) return clamp_to_max(5 * win[1][1] - edges);
    total = 0;
    for (r = 0; r < 3; r++)
      for (s = 0; s < 3; s++)
        total += win[r][s];
    return total / 9;
  endfunction

  // Advance the predictor by one accepted input beat; queues the output beat
  // it causes, if any. Output lags input by one row plus one pixel.
  function automatic void advance_filter(logic k, logic [s3f_pkg::PIX_FIELD_W-1:0] v);
    int          w, h, col, px, up, mid, r;
    bit          produce, interior;
    filtered_t   res;
    w   = active_width();
    h   = active_height();
    col = int'(col_in % LINE_DEPTH);
    // flush beats and anything past the last row enter as zero
    px  = (k == KIND_FLUSH || row_in >= h) ? 0 : int'(v);
    produce = row_in > 1 || (row_in == 1 && col_in >= 1);
    up  = int'(upper_line[col]);
    mid = int'(middle_line[col]);
    upper_line[col]  = mid[s3f_pkg::PIX_FIELD_W-1:0];
    middle_line[col] = px[s3f_pkg::PIX_FIELD_W-1:0];
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = px;

    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in = (row_in + 1) & 32'hFFFF;
    end
    if (!produce) return;

    interior  = row_out >= 1 && row_out + 2 <= h && col_out >= 1 && col_out + 2 <= w;
    res.pixel = s3f_pkg::PIX_FIELD_W'(interior ? window_value() : win[1][1]);
    res.last  = (row_out + 1 >= h) && (col_out + 1 >= w);
    pending_pixels.push_back(res);
    if (res.last) begin
      // end of frame: every position restarts
      col_in  = 0;
      row_in  = 0;
      col_out = 0;
      row_out = 0;
    end else begin
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out = (row_out + 1) & 32'hFFFF;
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Output check and input monitor. Checking runs first so a beat accepted
  // on the same edge can never satisfy a result that arrives with it.
  // --------------------------------------------------------------------------
  function automatic void report_mismatch(string what, int exp_v, int got_v);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: stray output beat, expected none, actual out_pixel %0d",
                   $time, out_pixel);
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel !== want.pixel)
          report_mismatch("out_pixel", int'(want.pixel), int'(out_pixel));
        if (frame_last !== want.last)
          report_mismatch("frame_last", int'(want.last), int'(frame_last));
      end
    end
    if (!rst && in_valid && in_ready === 1'b1) begin
      advance_filter(kind, pixel_value);
      beats_accepted++;
    end
  end

  // Global cycle limit; a hang anywhere lands here
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d beats still expected",
               $time, pending_pixels.size());
      $display("stencil_3x3_image_filter regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake helpers
  // --------------------------------------------------------------------------
  // when enabled, one third of beats go back to back and the rest get a random gap
  function automatic int draw_gap(bit enabled);
    if (!enabled || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Result sink: random ready gaps per beat, plus an optional long hold-off
  // counted here so the sender keeps pushing while the block backs up.
  initial begin : result_sink
    int gap;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        gap         = hold_cycles;
        hold_cycles = 0;
      end else begin
        gap = draw_gap(out_gaps_on);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  // Offer one input beat and return on the edge that accepts it. Valid stays
  // high afterwards so the next beat can follow with no bubble.
  task automatic send_beat(input logic k, input logic [s3f_pkg::PIX_FIELD_W-1:0] v);
    int gap;
    gap = draw_gap(in_gaps_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    pixel_value <= v;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  // Stop offering, wait for every predicted beat, then let the pipe empty
  // of beats that produce nothing before any register changes.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Caller lowers cfg_write after the last write of a group
  task automatic write_cfg(input logic [s3f_pkg::CFG_INDEX_W-1:0] index,
                           input logic [s3f_pkg::CFG_DATA_W-1:0]  data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    case (index)
      s3f_pkg::CFG_FILTER_MODE:  mode_reg   = data[1:0];
      s3f_pkg::CFG_FRAME_WIDTH:  width_reg  = data[10:0];
      s3f_pkg::CFG_FRAME_HEIGHT: height_reg = data;
      s3f_pkg::CFG_MAX_VALUE:    maxval_reg = data;
    endcase
  endtask

  // All four registers; unused upper data bits carry junk that must be ignored
  task automatic program_filter(input logic [1:0]  mode,
                                input logic [10:0] width,
                                input logic [15:0] height,
                                input logic [15:0] maxv);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_cfg(s3f_pkg::CFG_FILTER_MODE, {junk[15:2], mode});
    write_cfg(s3f_pkg::CFG_FRAME_WIDTH, {junk[15:11], width});
    write_cfg(s3f_pkg::CFG_FRAME_HEIGHT, height);
    write_cfg(s3f_pkg::CFG_MAX_VALUE, maxv);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [1:0] nth_mode(int i);
    case (i)
      0:       return s3f_pkg::MODE_BOX;
      1:       return s3f_pkg::MODE_LAPLACE;
      2:       return s3f_pkg::MODE_SHARPEN;
      default: return MODE_SPARE;
    endcase
  endfunction

  function automatic logic [s3f_pkg::PIX_FIELD_W-1:0] pick_pixel(pixel_pattern_t pat,
                                                                 int row, int col);
    logic [s3f_pkg::PIX_FIELD_W-1:0] any;
    any = s3f_pkg::PIX_FIELD_W'($urandom);
    case (pat)
      // checkerboard: interior centres alternate between a spike and a pit,
      // driving the clamp past both ends
      PAT_CHECKER: return ((row + col) % 2 == 0) ? PIX_ONES : '0;
      PAT_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return PIX_ONES;
          2:       return maxval_reg;
          default: return maxval_reg + 16'd1;
        endcase
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       return any;
          1:       return s3f_pkg::PIX_FIELD_W'(int'(any) % (int'(maxval_reg) + 1));
          2:       return any & 16'h00FF;
          default: return any;
        endcase
      end
    endcase
  endfunction

  // One whole frame at the current geometry: width*height positions, then
  // width+1 tail beats that push out the last row. Tail beats are a random
  // mix of flush beats and pixel beats past the frame end. noise_pct turns
  // that share of in-frame beats into flush beats. pause_at stops the sender
  // mid-frame until every predicted beat has come back (-1 for none).
  task automatic send_frame(input pixel_pattern_t pat, input int noise_pct, input int pause_at);
    int   w, h, total, n;
    logic k;
    w     = active_width();
    h     = active_height();
    total = w * h + w + 1;
    for (n = 0; n < total; n++) begin
      if (n == pause_at) settle();
      if (n < w * h)
        k = ($urandom_range(0, 99) < noise_pct) ? KIND_FLUSH : KIND_PIXEL;
      else
        k = $urandom_range(0, 1) ? KIND_FLUSH : KIND_PIXEL;
      send_beat(k, pick_pixel(pat, n / w, n % w));
    end
    frames_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Mode and max_value keep their reset values for the first frame; the second runs the Laplacian.
  task automatic test_reset_registers();
    write_cfg(s3f_pkg::CFG_FRAME_WIDTH, 16'd3);
    write_cfg(s3f_pkg::CFG_FRAME_HEIGHT, 16'd3);
    cfg_write <= 1'b0;
    send_frame(PAT_EXTREME, 0, -1);
    settle();
    write_cfg(s3f_pkg::CFG_FILTER_MODE, {14'd0, s3f_pkg::MODE_LAPLACE});
    cfg_write <= 1'b0;
    send_frame(PAT_CHECKER, 0, -1);
    settle();
  endtask

  // Every mode code, including the spare one, on small frames
  task automatic test_filter_modes();
    int i;
    for (i = 0; i < 4; i++) begin
      program_filter(nth_mode(i), 11'd4, 16'd4, 16'hFFFF);
      send_frame(PAT_EXTREME, 0, -1);
      settle();
      program_filter(nth_mode(i), 11'd5, 16'd3, 16'd255);
      send_frame(PAT_CHECKER, 0, -1);
      settle();
    end
  endtask

  // Clamp with the upper limit at zero, one, 1000 and full scale
  task automatic test_clamp_limits();
    program_filter(s3f_pkg::MODE_LAPLACE, 11'd5, 16'd4, 16'd0);
    send_frame(PAT_CHECKER, 0, -1);
    settle();
    program_filter(s3f_pkg::MODE_SHARPEN, 11'd5, 16'd4, 16'd1);
    send_frame(PAT_RANDOM, 0, -1);
    settle();
    program_filter(s3f_pkg::MODE_SHARPEN, 11'd4, 16'd5, 16'hFFFF);
    send_frame(PAT_CHECKER, 0, -1);
    settle();
    program_filter(s3f_pkg::MODE_LAPLACE, 11'd6, 16'd3, 16'd1000);
    send_frame(PAT_RANDOM, 0, -1);
    settle();
  endtask

  // Width below 3 and height below 3 both act as 3
  task automatic test_geometry_limits();
    program_filter(s3f_pkg::MODE_BOX, 11'd0, 16'd0, 16'd255);
    send_frame(PAT_RANDOM, 0, -1);
    settle();
    program_filter(s3f_pkg::MODE_SHARPEN, 11'd1, 16'd1, 16'd4095);
    send_frame(PAT_EXTREME, 0, -1);
    settle();
    program_filter(s3f_pkg::MODE_LAPLACE, 11'd2, 16'd2, 16'hFFFF);
    send_frame(PAT_RANDOM, 0, -1);
    settle();
  endtask

  // Flush beats mid-frame, pixel beats past the end, frames back to back
  task automatic test_frame_tails();
    program_filter(s3f_pkg::MODE_LAPLACE, 11'd6, 16'd4, 16'hFFFF);
    send_frame(PAT_RANDOM, 25, -1);
    send_frame(PAT_EXTREME, 40, -1);
    send_frame(PAT_RANDOM, 0, -1);
    settle();
  endtask

  // Long output stall while input keeps coming, then a mid-frame input pause
  task automatic test_backpressure();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    program_filter(s3f_pkg::MODE_SHARPEN, 11'd32, 16'd12, 16'd4095);
    hold_cycles = HOLD_OFF;
    send_frame(PAT_RANDOM, 0, -1);
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    send_frame(PAT_RANDOM, 0, 32 * 5 + 7);
    settle();
  endtask

  // Random geometry, mode and limit for most frames; mostly small frames, now and
  // then a wide one; frames that keep the previous settings follow with no pause.
  task automatic test_random_frames();
    int unsigned    start;
    int             noise;
    bit             first;
    logic [10:0]    width;
    logic [15:0]    height, maxv;
    pixel_pattern_t pat;
    start = beats_accepted;
    first = 1'b1;
    while (beats_accepted - start < RANDOM_BEATS) begin
      if (first || $urandom_range(0, 9) < 7) begin
        settle();
        in_gaps_on  = $urandom_range(0, 3) != 0;
        out_gaps_on = $urandom_range(0, 3) != 0;
        case ($urandom_range(0, 19))
          0, 1, 2: width = 11'($urandom_range(13, 64));
          default: width = 11'($urandom_range(0, 12));
        endcase
        height = (width > 11'd12) ? 16'($urandom_range(0, 3)) :
                 ($urandom_range(0, 9) == 0) ? 16'($urandom_range(8, 20)) :
                                               16'($urandom_range(0, 7));
        case ($urandom_range(0, 4))
          0:       maxv = 16'd0;
          1:       maxv = 16'hFFFF;
          2:       maxv = 16'd255;
          default: maxv = 16'($urandom);
        endcase
        program_filter(nth_mode($urandom_range(0, 3)), width, height, maxv);
        first = 1'b0;
      end
      noise = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(5, 40);
      case ($urandom_range(0, 5))
        0:       pat = PAT_EXTREME;
        1:       pat = PAT_CHECKER;
        default: pat = PAT_RANDOM;
      endcase
      send_frame(pat, noise, -1);
    end
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_predictor();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_registers();
    test_filter_modes();
    test_clamp_limits();
    test_geometry_limits();
    test_frame_tails();
    test_backpressure();
    test_random_frames();

    // anything still owed, or arriving late, shows up here
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      errors++;
      $display("%0t: %0d output beats never arrived, expected 0, actual %0d",
               $time, pending_pixels.size(), pending_pixels.size());
    end

    $display("run: %0d input beats, %0d output beats checked, %0d frames, %0d errors",
             beats_accepted, results_seen, frames_sent, errors);
    $display("scope: all mode codes, clamp limits 0..65535, widths 3..64, heights 3..20");
    if (errors == 0) begin
      $display("stencil_3x3_image_filter regression: pass");
    end else begin
      $display("stencil_3x3_image_filter regression: fail");
    end
    $finish;
  end

endmodule
